[rtl/ttc_pkg.sv]
// shared types and constants for the transient trigger capture unit
// no dependencies
package ttc_pkg;

	localparam logic [22:0] MAG_MAX    = 23'd8388607;
	localparam logic [22:0] FLOOR_INIT = 23'd167772;
	localparam int          CNT_W      = 6;

	localparam logic [2:0] CFG_NUM_CH  = 3'd0;
	localparam logic [2:0] CFG_BLK_LEN = 3'd1;
	localparam logic [2:0] CFG_RATIO   = 3'd2;
	localparam logic [2:0] CFG_MIN     = 3'd3;
	localparam logic [2:0] CFG_HOLDOFF = 3'd4;

	typedef enum logic [1:0] {
		MODE_ARMED = 2'd0,
		MODE_FILL  = 2'd1,
		MODE_HOLD  = 2'd2
	} mode_t;

	typedef struct packed {
		logic start;
	} unit_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

[rtl/ttc_ram.sv]
// generic simple dual-port ram, one write and one registered read
// no dependencies
module ttc_ram #(
	parameter int W = 24,
	parameter int D = 1024
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/ttc_div.sv]
// iterative restoring divider, one quotient bit per cycle
// depends on ttc_pkg
module ttc_div
	import ttc_pkg::*;
#(
	parameter int DW = 61,
	parameter int VW = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	input  unit_ctl_t     ctl,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output unit_sts_t     sts,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] dvd_q;
	logic [VW-1:0] dsr_q;
	logic [VW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic          ge;

	assign trial = {rem_q, dvd_q[DW-1]};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			dvd_q  <= dividend;
			dsr_q  <= divisor;
			rem_q  <= '0;
			cnt_q  <= CW'(DW);
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			rem_q <= ge ? VW'(trial - {1'b0, dsr_q}) : VW'(trial);
			dvd_q <= {dvd_q[DW-2:0], ge};
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign sts.busy = run_q;
	assign sts.done = done_q;
	assign quotient = dvd_q;

endmodule

[rtl/ttc_sqrt.sv]
// iterative integer square root, one result bit per cycle
// depends on ttc_pkg
module ttc_sqrt
	import ttc_pkg::*;
#(
	parameter int IW = 61
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  unit_ctl_t             ctl,
	input  logic [IW-1:0]         radicand,
	output unit_sts_t             sts,
	output logic [(IW+1)/2-1:0]   root
);

	localparam int N  = (IW + 1) / 2;
	localparam int W  = 2 * N;
	localparam int CW = $clog2(N + 1);

	logic [W-1:0]  x_q;
	logic [N:0]    rem_q;
	logic [N-1:0]  root_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [N+2:0]  t;
	logic [N+2:0]  trial;
	logic          ge;

	assign t     = {rem_q, x_q[W-1:W-2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = t >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			x_q    <= W'(radicand);
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= CW'(N);
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			rem_q  <= ge ? (N+1)'(t - trial) : (N+1)'(t);
			root_q <= {root_q[N-2:0], ge};
			x_q    <= {x_q[W-3:0], 2'b00};
			cnt_q  <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign sts.busy = run_q;
	assign sts.done = done_q;
	assign root     = root_q;

endmodule

[rtl/transient_trigger_capture_unit.sv]
// top level of the transient trigger capture unit: sequencer, state and memories
// depends on ttc_pkg, ttc_ram, ttc_div, ttc_sqrt
//
// One beat in at a time; s_axis_tready is high only while the sequencer idles.
// A sample beat passes through S_POS, which wraps its ring position if needed and
// writes the ring, and S_ACC. A snapshot read passes through S_RD_WAIT and S_RD_OUT
// and gives one beat. A block end runs, per channel, a divide by block_len and a
// square root through the shared iterative units, then a reciprocal multiply for
// the divide by five; the trigger step follows, the snapshot copy goes through the
// ring read port, and the reports leave at one beat per cycle while m_axis_tready
// is high. No clearing pass after reset.
module transient_trigger_capture_unit
	import ttc_pkg::*;
#(
	parameter int RING_DEPTH   = 16384,
	parameter int MAX_CHANNELS = 19,
	parameter int SNAP_LEN     = 4096,
	parameter int SNAP_PRE     = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [22:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [47:0]  s_axis_tdata,  // channel, sample, snap_index
	input  logic         s_axis_tuser,  // req_type
	input  logic         s_axis_tlast,  // block_end
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [119:0] m_axis_tdata,  // out_channel, value, noise_floor, trigger_state,
	                                    // snapshot_count, block_count
	output logic         m_axis_tuser,  // result_kind
	output logic         m_axis_tlast   // last
);

	localparam int RPW    = $clog2(RING_DEPTH);
	localparam int POSW   = (RPW > 14 ? RPW : 14) + 1;
	localparam int CHW    = MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1;
	localparam int RWORDS = MAX_CHANNELS * RING_DEPTH;
	localparam int RAW    = $clog2(RWORDS);
	localparam int SWORDS = MAX_CHANNELS * SNAP_LEN;
	localparam int SAW    = $clog2(SWORDS);
	localparam int SIW    = $clog2(SNAP_LEN);
	localparam int PREMOD = SNAP_PRE % RING_DEPTH;
	localparam int THR    = SNAP_LEN - SNAP_PRE;
	localparam logic [POSW-1:0] RD_P = POSW'(RING_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE, S_RD_WAIT, S_RD_OUT, S_POS, S_ACC, S_BE, S_DIV1, S_SQRT,
		S_SMOOTH, S_TRIG, S_FLOOR, S_WRAP, S_CP, S_REP
	} state_t;

	state_t state_q;

	logic [4:0]  num_ch_q;
	logic [13:0] bl_q;
	logic [9:0]  ratio_q;
	logic [22:0] tmin_q;
	logic [15:0] hold_q;

	logic [60:0] energy_q [MAX_CHANNELS];
	logic [22:0] smooth_q [MAX_CHANNELS];
	logic [13:0] offset_q [MAX_CHANNELS];
	logic [22:0] peak_q;
	logic [22:0] floor_q;
	logic [RPW-1:0] write_pos_q;
	logic        filled_q;
	logic [RPW-1:0] trig_pos_q;
	logic [13:0] since_q;
	mode_t       mode_q;
	logic [15:0] holdoff_q;
	logic [31:0] snap_cnt_q;
	logic [31:0] blk_cnt_q;

	logic        req_q;
	logic [4:0]  ch_q;
	logic signed [23:0] sample_q;
	logic        bend_q;
	logic [11:0] idx_q;
	logic [POSW-1:0] pos_q;
	logic [47:0] sq_s1;
	logic [CNT_W-1:0] c_q;
	logic        cp_go_q;
	logic [CNT_W-1:0] cp_c_q;
	logic [SIW-1:0] cp_i_q;
	logic [RPW-1:0] ri_q;
	logic [RPW-1:0] s0_q;
	logic        cp_pend_s1;
	logic [SAW-1:0] cp_wa_s1;

	logic [60:0] div_a_q;
	logic [13:0] div_b_q;
	logic        div_go_q;
	logic [60:0] sq_in_q;
	logic        sq_go_q;

	logic        out_valid_q;
	logic        out_kind_q;
	logic [4:0]  out_ch_q;
	logic [23:0] out_val_q;
	logic [22:0] out_floor_q;
	logic [1:0]  out_mode_q;
	logic [31:0] out_snap_q;
	logic [31:0] out_blk_q;
	logic        out_last_q;

	unit_ctl_t   div_ctl, sq_ctl;
	unit_sts_t   div_sts, sq_sts;
	logic [60:0] div_q;
	logic [30:0] root;

	logic [23:0] ring_rdata, snap_rdata;
	logic        ring_we;
	logic [RAW-1:0] ring_waddr, ring_raddr;
	logic [SAW-1:0] snap_raddr;

	logic [CNT_W-1:0] nch;
	logic [13:0] bl_div;
	logic        out_free;
	logic [4:0]  in_ch;
	logic [13:0] in_off;
	logic        in_active;
	logic signed [47:0] prod;
	logic [23:0] absv;
	logic [22:0] mag;
	logic [22:0] rms;
	logic [POSW-1:0] next_pos;
	logic        filled_now;
	logic        fire;
	logic [32:0] ratio_floor;
	logic [14:0] since_sum;
	logic [13:0] since_new;
	logic [RPW:0] s0_sum;
	logic [RPW-1:0] s0;
	logic        rd_ok;
	logic [57:0] smooth_prod;
	logic [60:0] floor_prod;

	assign nch = ({1'b0, num_ch_q} > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS)
	                                                        : CNT_W'(num_ch_q);
	assign bl_div   = (bl_q == 14'd0) ? 14'd1 : bl_q;
	assign out_free = !out_valid_q || m_axis_tready;

	assign in_ch     = s_axis_tdata[4:0];
	assign in_off    = offset_q[in_ch[CHW-1:0]];
	assign in_active = (CNT_W'(in_ch) < nch) && (in_off < bl_q);

	assign prod = sample_q * sample_q;
	assign absv = sample_q[23] ? (~sample_q + 24'd1) : sample_q;
	assign mag  = (absv > {1'b0, MAG_MAX}) ? MAG_MAX : absv[22:0];
	assign rms  = (root > 31'(MAG_MAX)) ? MAG_MAX : root[22:0];

	// reciprocal multiplies, exact over the numerator ranges used here
	assign smooth_prod = div_a_q[25:0] * 32'd3435973837;
	assign floor_prod  = div_a_q[28:0] * 32'd2748779070;

	assign next_pos    = POSW'(write_pos_q) + POSW'(bl_q);
	assign filled_now  = filled_q || (next_pos > RD_P);
	assign ratio_floor = ratio_q * floor_q;
	assign fire = filled_now && ({6'd0, peak_q, 4'd0} > ratio_floor) && (peak_q > tmin_q);
	assign since_sum = 15'(since_q) + 15'(bl_q);
	assign since_new = (since_sum > 15'd16383) ? 14'd16383 : since_sum[13:0];
	assign s0_sum = (RPW+1)'(trig_pos_q) + (RPW+1)'(RING_DEPTH - PREMOD);
	assign s0 = (s0_sum >= (RPW+1)'(RING_DEPTH)) ? RPW'(s0_sum - (RPW+1)'(RING_DEPTH))
	                                            : RPW'(s0_sum);
	assign rd_ok = (CNT_W'(ch_q) < CNT_W'(MAX_CHANNELS)) && (14'(idx_q) < 14'(SNAP_LEN));

	assign ring_we    = (state_q == S_POS) && (pos_q < RD_P);
	assign ring_waddr = RAW'(ch_q) * RAW'(RING_DEPTH) + RAW'(pos_q);
	assign ring_raddr = RAW'(cp_c_q) * RAW'(RING_DEPTH) + RAW'(ri_q);
	assign snap_raddr = SAW'(ch_q) * SAW'(SNAP_LEN) + SAW'(idx_q);

	assign div_ctl.start = div_go_q;
	assign sq_ctl.start  = sq_go_q;

	ttc_ram #(.W(24), .D(RWORDS)) u_ring (
		.clk(clk), .we(ring_we), .waddr(ring_waddr), .wdata(sample_q),
		.raddr(ring_raddr), .rdata(ring_rdata)
	);

	ttc_ram #(.W(24), .D(SWORDS)) u_snap (
		.clk(clk), .we(cp_pend_s1), .waddr(cp_wa_s1), .wdata(ring_rdata),
		.raddr(snap_raddr), .rdata(snap_rdata)
	);

	ttc_div #(.DW(61), .VW(14)) u_div (
		.clk(clk), .arst_n(arst_n), .ctl(div_ctl), .dividend(div_a_q),
		.divisor(div_b_q), .sts(div_sts), .quotient(div_q)
	);

	ttc_sqrt #(.IW(61)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .ctl(sq_ctl), .radicand(sq_in_q),
		.sts(sq_sts), .root(root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			num_ch_q    <= 5'd19;
			bl_q        <= 14'd256;
			ratio_q     <= 10'd128;
			tmin_q      <= 23'd41943;
			hold_q      <= 16'd57;
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				energy_q[i] <= '0;
				smooth_q[i] <= '0;
				offset_q[i] <= '0;
			end
			peak_q      <= '0;
			floor_q     <= FLOOR_INIT;
			write_pos_q <= '0;
			filled_q    <= 1'b0;
			trig_pos_q  <= '0;
			since_q     <= '0;
			mode_q      <= MODE_ARMED;
			holdoff_q   <= '0;
			snap_cnt_q  <= '0;
			blk_cnt_q   <= '0;
			c_q         <= '0;
			cp_go_q     <= 1'b0;
			cp_pend_s1  <= 1'b0;
			div_go_q    <= 1'b0;
			sq_go_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			sq_go_q  <= 1'b0;
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_NUM_CH:  num_ch_q <= cfg_data[4:0];
					CFG_BLK_LEN: bl_q     <= cfg_data[13:0];
					CFG_RATIO:   ratio_q  <= cfg_data[9:0];
					CFG_MIN:     tmin_q   <= cfg_data[22:0];
					CFG_HOLDOFF: hold_q   <= cfg_data[15:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						req_q    <= s_axis_tuser;
						ch_q     <= in_ch;
						sample_q <= s_axis_tdata[28:5];
						bend_q   <= s_axis_tlast;
						idx_q    <= s_axis_tdata[40:29];
						pos_q    <= POSW'(write_pos_q) + POSW'(in_off);
						c_q      <= '0;
						if (s_axis_tuser) begin
							state_q <= S_RD_WAIT;
						end else if (in_active) begin
							state_q <= S_POS;
						end else if (s_axis_tlast) begin
							state_q <= S_BE;
						end
					end
				end
				S_RD_WAIT: state_q <= S_RD_OUT;
				S_RD_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= 1'b1;
						out_ch_q    <= ch_q;
						out_val_q   <= rd_ok ? snap_rdata : 24'd0;
						out_floor_q <= floor_q;
						out_mode_q  <= mode_q;
						out_snap_q  <= snap_cnt_q;
						out_blk_q   <= blk_cnt_q;
						out_last_q  <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_POS: begin
					if (pos_q >= RD_P) begin
						pos_q <= pos_q - RD_P;
					end else begin
						offset_q[ch_q[CHW-1:0]] <= offset_q[ch_q[CHW-1:0]] + 14'd1;
						if (mag > peak_q) begin
							peak_q <= mag;
						end
						sq_s1   <= 48'(prod);
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					energy_q[ch_q[CHW-1:0]] <= energy_q[ch_q[CHW-1:0]] + 61'(sq_s1);
					state_q <= bend_q ? S_BE : S_IDLE;
				end
				S_BE: begin
					if (c_q < nch) begin
						div_a_q  <= energy_q[c_q[CHW-1:0]];
						div_b_q  <= bl_div;
						div_go_q <= 1'b1;
						state_q  <= S_DIV1;
					end else begin
						state_q <= S_TRIG;
					end
				end
				S_DIV1: begin
					if (div_sts.done) begin
						sq_in_q <= div_q;
						sq_go_q <= 1'b1;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sq_sts.done) begin
						div_a_q  <= 61'({2'b00, smooth_q[c_q[CHW-1:0]], 2'b00})
						            + 61'(rms) + 61'd2;
						state_q  <= S_SMOOTH;
					end
				end
				S_SMOOTH: begin
					smooth_q[c_q[CHW-1:0]] <= smooth_prod[56:34];
					c_q     <= c_q + CNT_W'(1);
					state_q <= S_BE;
				end
				S_TRIG: begin
					pos_q   <= next_pos;
					c_q     <= '0;
					cp_c_q  <= '0;
					cp_i_q  <= '0;
					cp_go_q <= 1'b0;
					state_q <= S_WRAP;
					if (next_pos >= RD_P) begin
						filled_q <= 1'b1;
					end
					unique case (mode_q)
						MODE_ARMED: begin
							if (fire) begin
								trig_pos_q <= write_pos_q;
								since_q    <= bl_q;
								mode_q     <= MODE_FILL;
							end else begin
								div_a_q  <= 61'(floor_q) * 61'd49 + 61'(peak_q) + 61'd25;
								state_q  <= S_FLOOR;
							end
						end
						MODE_FILL: begin
							since_q <= since_new;
							if (15'(since_new) >= 15'(THR)) begin
								cp_go_q    <= 1'b1;
								s0_q       <= s0;
								ri_q       <= s0;
								snap_cnt_q <= snap_cnt_q + 32'd1;
								holdoff_q  <= hold_q;
								mode_q     <= MODE_HOLD;
							end
						end
						default: begin
							if (holdoff_q <= 16'd1) begin
								holdoff_q <= '0;
								mode_q    <= MODE_ARMED;
							end else begin
								holdoff_q <= holdoff_q - 16'd1;
							end
						end
					endcase
				end
				S_FLOOR: begin
					floor_q <= floor_prod[59:37];
					state_q <= S_WRAP;
				end
				S_WRAP: begin
					if (pos_q >= RD_P) begin
						pos_q <= pos_q - RD_P;
					end else begin
						write_pos_q <= RPW'(pos_q);
						blk_cnt_q   <= blk_cnt_q + 32'd1;
						state_q     <= cp_go_q ? S_CP : S_REP;
					end
				end
				S_CP: begin
					if (cp_c_q < nch) begin
						cp_pend_s1 <= 1'b1;
						cp_wa_s1   <= SAW'(cp_c_q) * SAW'(SNAP_LEN) + SAW'(cp_i_q);
						if (cp_i_q == SIW'(SNAP_LEN - 1)) begin
							cp_i_q <= '0;
							cp_c_q <= cp_c_q + CNT_W'(1);
							ri_q   <= s0_q;
						end else begin
							cp_i_q <= cp_i_q + SIW'(1);
							ri_q   <= (ri_q == RPW'(RING_DEPTH - 1)) ? '0 : ri_q + RPW'(1);
						end
					end else begin
						cp_pend_s1 <= 1'b0;
						state_q    <= S_REP;
					end
				end
				S_REP: begin
					if (c_q >= nch) begin
						for (int i = 0; i < MAX_CHANNELS; i++) begin
							energy_q[i] <= '0;
							offset_q[i] <= '0;
						end
						peak_q  <= '0;
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= 1'b0;
						out_ch_q    <= 5'(c_q);
						out_val_q   <= {1'b0, smooth_q[c_q[CHW-1:0]]};
						out_floor_q <= floor_q;
						out_mode_q  <= mode_q;
						out_snap_q  <= snap_cnt_q;
						out_blk_q   <= blk_cnt_q;
						out_last_q  <= (c_q + CNT_W'(1)) == nch;
						c_q         <= c_q + CNT_W'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {2'b00, out_blk_q, out_snap_q, out_mode_q, out_floor_q,
	                        out_val_q, out_ch_q};

endmodule
